// ===== hw/rtl/lse_pkg.sv =====
// ----------------------------------------------------------------------------
// lse_pkg - LSB stego embed/extract shared definitions
// Widths, register codes and mode codes for the embed/extract unit.
// ----------------------------------------------------------------------------
package lse_pkg;

    localparam int CARRIER_W = 8;
    localparam int LEN_W     = 32;
    localparam int POS_W     = 36;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [CARRIER_W-1:0] LSB_CLEAR_MASK = 8'hFE;

    // register index, taken from paddr[2]
    localparam logic REG_EXTRACT_MODE = 1'b0;
    localparam logic REG_EMBED_LENGTH = 1'b1;

    // extract_mode codes
    localparam logic MODE_EMBED   = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [LEN_W-1:0] t_len;
    typedef logic [CARRIER_W-1:0] t_byte;

endpackage

// ===== hw/rtl/lsb_stego_embed_extract_unit.sv =====
// ----------------------------------------------------------------------------
// lsb_stego_embed_extract_unit - LSB steganography embed / extract
// Hides or recovers one message bit per carrier byte LSB, with a length
// header in the first HEADER_BITS carrier bytes of each image.
//
//  Channel   Dir  Sync            Contents
//  s_axis    in   tvalid/tready   tdata: carrier_byte[7:0], message_byte[15:8]
//                                 tuser: start_of_image
//  m_axis    out  tvalid/tready   tdata: carrier_out, recovered_byte,
//                                 decoded_length; tuser: flags
//  apb       in   psel/penable    reg 0 extract_mode @0x0, reg 1 embed_length @0x4
//
// One transfer per cycle unless the output is stalled; each result is held in the output register.
// Per-item work is a 36-bit increment and compare against the total length.
// s_axis_tready drops only while the output register is full and stalled.
// i_rst_n is synchronous; reset clears all stream state and both registers.
// ----------------------------------------------------------------------------
module lsb_stego_embed_extract_unit #(
    parameter int HEADER_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // carrier_byte[7:0], message_byte[15:8]
    input  logic        s_axis_tuser,   // start_of_image
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // carrier_out[7:0], recovered_byte[15:8],
                                        // decoded_length[47:16]
    output logic [2:0]  m_axis_tuser,   // recovered_valid[0], need_message_byte[1],
                                        // finished[2]
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lse_pkg::APB_AW-1:0]  paddr,
    input  logic [lse_pkg::APB_DW-1:0]  pwdata,
    output logic [lse_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    localparam logic [lse_pkg::LEN_W-1:0] HDR_MASK =
        lse_pkg::LEN_W'((64'd1 << HEADER_BITS) - 64'd1);
    localparam lse_pkg::t_pos HDR_BITS_POS = lse_pkg::POS_W'(HEADER_BITS);
    localparam logic [2:0]   HDR_BITS_LO  = 3'(HEADER_BITS % 8);

    // configuration registers
    logic          r_extract_mode;
    lse_pkg::t_len r_embed_length;

    // stream state
    lse_pkg::t_pos  r_pos,  n_pos;
    lse_pkg::t_len  r_latch, n_latch;
    lse_pkg::t_byte r_asm,  n_asm;
    lse_pkg::t_byte r_held, n_held;
    logic           r_done, n_done;

    // output register
    logic           r_out_valid;
    lse_pkg::t_byte r_carrier_out,  n_carrier_out;
    lse_pkg::t_byte r_rec_byte,     n_rec_byte;
    logic           r_rec_valid,    n_rec_valid;
    logic           r_need,         n_need;
    lse_pkg::t_len  r_dec_len,      n_dec_len;
    logic           r_finished;

    logic           s_accept;
    logic           cfg_write;
    logic           sof;
    lse_pkg::t_byte carrier;
    lse_pkg::t_byte msg;
    lse_pkg::t_pos  p;
    lse_pkg::t_len  latch_in;
    lse_pkg::t_byte asm_in;
    lse_pkg::t_byte held_in;
    logic           done_in;
    logic           in_header;
    logic [2:0]     k;
    logic           bit_out;
    lse_pkg::t_pos  total_bits;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = (paddr[2] == lse_pkg::REG_EMBED_LENGTH) ? r_embed_length
                     : {{(lse_pkg::APB_DW-1){1'b0}}, r_extract_mode};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_extract_mode <= lse_pkg::MODE_EMBED;
            r_embed_length <= '0;
        end else if (cfg_write) begin
            case (paddr[2])
                lse_pkg::REG_EXTRACT_MODE: r_extract_mode <= pwdata[0];
                lse_pkg::REG_EMBED_LENGTH: r_embed_length <= pwdata;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign sof     = s_axis_tuser;
    assign carrier = s_axis_tdata[7:0];
    assign msg     = s_axis_tdata[15:8];

    // start of image clears the state before the item is handled
    assign p        = sof ? '0 : r_pos;
    assign latch_in = sof ? '0 : r_latch;
    assign asm_in   = sof ? '0 : r_asm;
    assign held_in  = sof ? '0 : r_held;
    assign done_in  = sof ? 1'b0 : r_done;

    assign in_header = (p < HDR_BITS_POS);
    assign k         = p[2:0] - HDR_BITS_LO;

    always_comb begin
        n_pos         = p;
        n_latch       = latch_in;
        n_asm         = asm_in;
        n_held        = held_in;
        n_carrier_out = carrier;
        n_rec_byte    = '0;
        n_rec_valid   = 1'b0;
        n_need        = 1'b0;
        bit_out       = 1'b0;
        if (!done_in) begin
            if (r_extract_mode == lse_pkg::MODE_EMBED) begin
                if (p == '0) begin
                    n_latch = r_embed_length & HDR_MASK;
                end
                if (in_header) begin
                    bit_out = n_latch[p[4:0]];
                end else begin
                    if (k == 3'd0) begin
                        n_held = msg;
                        n_need = 1'b1;
                    end
                    bit_out = n_held[k];
                end
                n_carrier_out = (carrier & lse_pkg::LSB_CLEAR_MASK)
                              | {7'd0, bit_out};
            end else begin
                if (in_header) begin
                    n_latch[p[4:0]] = latch_in[p[4:0]] | carrier[0];
                end else begin
                    n_asm[k] = asm_in[k] | carrier[0];
                    if (k == 3'd7) begin
                        n_rec_byte  = n_asm;
                        n_rec_valid = 1'b1;
                        n_asm       = '0;
                    end
                end
            end
            n_pos = p + lse_pkg::POS_W'(1);
        end
        n_dec_len = (r_extract_mode == lse_pkg::MODE_EXTRACT) ? n_latch : '0;
    end

    assign total_bits = HDR_BITS_POS + {1'b0, n_latch, 3'b000};
    assign n_done     = done_in || (n_pos >= total_bits);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_latch <= '0;
            r_asm   <= '0;
            r_held  <= '0;
            r_done  <= 1'b0;
        end else if (s_accept) begin
            r_pos   <= n_pos;
            r_latch <= n_latch;
            r_asm   <= n_asm;
            r_held  <= n_held;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_carrier_out <= n_carrier_out;
            r_rec_byte    <= n_rec_byte;
            r_rec_valid   <= n_rec_valid;
            r_need        <= n_need;
            r_dec_len     <= n_dec_len;
            r_finished    <= n_done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_dec_len, r_rec_byte, r_carrier_out};
    assign m_axis_tuser  = {r_finished, r_need, r_rec_valid};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_done_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_pos >= HDR_BITS_POS))
        else $error("done set inside header");

    a_pos_holds_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && !sof && r_done) |=> $stable(r_pos))
        else $error("bit position moved after done");

    a_need_excludes_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_need && r_rec_valid))
        else $error("embed and extract flags together");

    a_rec_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_rec_valid) |-> (r_rec_byte == '0))
        else $error("recovered byte set without valid");

endmodule

// ===== tb/tb_lsb_stego_embed_extract_unit.sv =====
// ----------------------------------------------------------------------------
// tb_lsb_stego_embed_extract_unit - LSB stego embed/extract unit testbench
// Drives carrier/message transfers on s_axis and programs the mode and length
// registers over APB. An in-bench predictor tracks bit position, length header,
// byte assembly and done state. Every m_axis transfer is checked field by field
// against it or a typed row's own entry. A short directed table runs first,
// then randomized images with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb_lsb_stego_embed_extract_unit;

    localparam int          HDR_BITS    = 32;
    localparam int unsigned N_ITEMS     = 900;
    localparam int unsigned LONG_HOLD   = 250;
    localparam int unsigned STALL_LIMIT = 5000;
    localparam logic [63:0] HDR_MASK    = (64'd1 << HDR_BITS) - 64'd1;

    typedef struct packed {
        logic           finished;
        logic           need_byte;
        logic           rec_valid;
        lse_pkg::t_len  dec_len;
        lse_pkg::t_byte rec_byte;
        lse_pkg::t_byte carrier_out;
    } t_stego_result;

    typedef struct packed {
        logic          typed;
        t_stego_result want;
    } t_item_tag;

    typedef enum logic [1:0] {ROW_ITEM, ROW_SET_MODE, ROW_SET_LEN} t_row_kind;

    typedef struct packed {
        t_row_kind      kind;
        logic [31:0]    value;
        logic           sof;
        lse_pkg::t_byte carrier;
        lse_pkg::t_byte msg;
        logic           typed;
        t_stego_result  want;
    } t_stim_row;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [lse_pkg::APB_AW-1:0] paddr   = '0;
    logic [lse_pkg::APB_DW-1:0] pwdata  = '0;
    logic [lse_pkg::APB_DW-1:0] prdata;
    logic                       pready;

    // predictor state and register copies
    lse_pkg::t_pos  pos_m  = '0;
    lse_pkg::t_len  len_m  = '0;
    lse_pkg::t_byte asm_m  = '0;
    lse_pkg::t_byte held_m = '0;
    logic           done_m = 1'b0;
    logic           mode_m = lse_pkg::MODE_EMBED;
    lse_pkg::t_len  elen_m = '0;

    t_stego_result pending_outputs[$];
    t_item_tag     directed_tags[$];
    int unsigned   items_in     = 0;
    int unsigned   outputs_seen = 0;
    int unsigned   items_sent   = 0;
    int unsigned   burst_left   = 0;
    int unsigned   mismatches   = 0;

    t_stim_row script [0:18] = '{
        '{ROW_ITEM, 32'd0, 1'b0, 8'hFF, 8'h00, 1'b1, '{carrier_out: 8'hFE, default: '0}},
        '{ROW_ITEM, 32'd0, 1'b0, 8'h00, 8'hFF, 1'b1, '0},
        '{ROW_SET_LEN, 32'hFFFF_FFFF, 1'b0, 8'h00, 8'h00, 1'b0, '0},
        '{ROW_SET_MODE, 32'(lse_pkg::MODE_EMBED), 1'b0, 8'h00, 8'h00, 1'b0, '0},
        '{ROW_ITEM, 32'd0, 1'b1, 8'h00, 8'h5A, 1'b1, '{carrier_out: 8'h01, default: '0}},
        '{ROW_ITEM, 32'd0, 1'b0, 8'hFE, 8'h00, 1'b1, '{carrier_out: 8'hFF, default: '0}},
        '{ROW_ITEM, 32'd0, 1'b0, 8'h80, 8'hFF, 1'b0, '0},
        '{ROW_SET_LEN, 32'd0, 1'b0, 8'h00, 8'h00, 1'b0, '0},
        '{ROW_ITEM, 32'd0, 1'b0, 8'h7F, 8'hA5, 1'b0, '0},
        '{ROW_SET_MODE, 32'(lse_pkg::MODE_EXTRACT), 1'b0, 8'h00, 8'h00, 1'b0, '0},
        '{ROW_ITEM, 32'd0, 1'b0, 8'h01, 8'h00, 1'b0, '0},
        '{ROW_ITEM, 32'd0, 1'b0, 8'hFE, 8'hFF, 1'b0, '0},
        '{ROW_ITEM, 32'd0, 1'b1, 8'hFF, 8'h00, 1'b1,
            '{carrier_out: 8'hFF, dec_len: 32'd1, default: '0}},
        '{ROW_ITEM, 32'd0, 1'b1, 8'h00, 8'hFF, 1'b1, '0},
        '{ROW_ITEM, 32'd0, 1'b0, 8'h81, 8'h7E, 1'b0, '0},
        '{ROW_SET_MODE, 32'(lse_pkg::MODE_EMBED), 1'b0, 8'h00, 8'h00, 1'b0, '0},
        '{ROW_ITEM, 32'd0, 1'b1, 8'h55, 8'hC3, 1'b0, '0},
        '{ROW_ITEM, 32'd0, 1'b0, 8'hAA, 8'h3C, 1'b0, '0},
        '{ROW_SET_LEN, 32'd1, 1'b0, 8'h00, 8'h00, 1'b0, '0}
    };

    lsb_stego_embed_extract_unit #(.HEADER_BITS(HDR_BITS)) dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic t_stego_result stego_predict(logic sof, lse_pkg::t_byte carrier,
                                                    lse_pkg::t_byte msg);
        t_stego_result r;
        logic          lsb;
        logic          b;
        lse_pkg::t_pos k_pos;
        logic [2:0]    k;
        r     = '0;
        lsb   = carrier[0];
        r.carrier_out = carrier;
        if (sof) begin
            pos_m  = '0;
            len_m  = '0;
            asm_m  = '0;
            held_m = '0;
            done_m = 1'b0;
        end
        if (!done_m) begin
            k_pos = pos_m - lse_pkg::t_pos'(HDR_BITS);
            k     = k_pos[2:0];
            if (mode_m == lse_pkg::MODE_EMBED) begin
                if (pos_m == '0)
                    len_m = elen_m & HDR_MASK[31:0];
                if (pos_m < lse_pkg::t_pos'(HDR_BITS)) begin
                    b = len_m[pos_m[4:0]];
                end else begin
                    if (k == 3'd0) begin
                        held_m      = msg;
                        r.need_byte = 1'b1;
                    end
                    b = held_m[k];
                end
                r.carrier_out = (carrier & lse_pkg::LSB_CLEAR_MASK) | lse_pkg::t_byte'(b);
            end else begin
                if (pos_m < lse_pkg::t_pos'(HDR_BITS)) begin
                    len_m = len_m | (lse_pkg::t_len'(lsb) << pos_m[4:0]);
                end else begin
                    asm_m = asm_m | (lse_pkg::t_byte'(lsb) << k);
                    if (k == 3'd7) begin
                        r.rec_byte  = asm_m;
                        r.rec_valid = 1'b1;
                        asm_m       = '0;
                    end
                end
            end
            pos_m = pos_m + lse_pkg::t_pos'(1);
            if (pos_m >= lse_pkg::t_pos'(HDR_BITS) + (lse_pkg::t_pos'(len_m) << 3))
                done_m = 1'b1;
        end
        r.dec_len  = (mode_m == lse_pkg::MODE_EXTRACT) ? len_m : '0;
        r.finished = done_m;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        mismatches++;
        if (mismatches <= 100)
            $display("[%0t] %s mismatch: got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    task automatic reg_write(logic sel, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == lse_pkg::REG_EXTRACT_MODE)
            mode_m = value[0];
        else
            elen_m = value;
    endtask

    task automatic send_item(logic sof, lse_pkg::t_byte carrier, lse_pkg::t_byte msg,
                             logic typed, t_stego_result want);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        directed_tags.push_back('{typed, want});
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {msg, carrier};
        s_axis_tuser  <= sof;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // drop valid and wait until every expected transfer has come back
    task automatic stream_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (items_in != outputs_seen) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic send_image();
        logic           xmode;
        lse_pkg::t_len  len;
        int unsigned    n;
        int unsigned    split_at;
        int unsigned    i;
        int unsigned    pick;
        logic           noise;
        logic           with_sof;
        lse_pkg::t_byte carrier;
        pick = $urandom_range(0, 19);
        if (pick < 4)
            len = '0;
        else if (pick < 16)
            len = lse_pkg::t_len'($urandom_range(1, 4));
        else if (pick < 18)
            len = lse_pkg::t_len'($urandom);
        else
            len = '1;
        xmode = logic'($urandom_range(0, 1));
        if (len > 8)
            n = HDR_BITS + $urandom_range(0, 40);
        else
            n = HDR_BITS + 8 * len + $urandom_range(0, 6);
        if ($urandom_range(0, 6) == 0)
            n = $urandom_range(1, n);
        noise    = ($urandom_range(0, 9) == 0);
        with_sof = ($urandom_range(0, 19) != 0);
        split_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n) : 0;
        stream_idle();
        reg_write(lse_pkg::REG_EXTRACT_MODE, {31'd0, xmode});
        reg_write(lse_pkg::REG_EMBED_LENGTH, len);
        for (i = 0; i < n; i++) begin
            if (split_at != 0 && i == split_at) begin
                // mode flip in the middle of an image
                stream_idle();
                xmode = ~xmode;
                reg_write(lse_pkg::REG_EXTRACT_MODE, {31'd0, xmode});
                if ($urandom_range(0, 1) == 1)
                    reg_write(lse_pkg::REG_EMBED_LENGTH, $urandom);
            end
            carrier = lse_pkg::t_byte'($urandom);
            if (xmode == lse_pkg::MODE_EXTRACT && !noise && i < HDR_BITS)
                carrier[0] = len[i];
            send_item(with_sof && i == 0, carrier, lse_pkg::t_byte'($urandom), 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_item_tag     tag;
        t_stego_result pred;
        t_stego_result want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                tag = '0;
                if (directed_tags.size() != 0)
                    tag = directed_tags.pop_front();
                pred = stego_predict(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8]);
                pending_outputs.push_back(tag.typed ? tag.want : pred);
                items_in++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                outputs_seen++;
                if (pending_outputs.size() == 0) begin
                    report_mismatch("unexpected transfer", m_axis_tdata, 0);
                end else begin
                    want = pending_outputs.pop_front();
                    if (m_axis_tdata[7:0] !== want.carrier_out)
                        report_mismatch("carrier_out", m_axis_tdata[7:0], want.carrier_out);
                    if (m_axis_tdata[15:8] !== want.rec_byte)
                        report_mismatch("recovered_byte", m_axis_tdata[15:8], want.rec_byte);
                    if (m_axis_tdata[47:16] !== want.dec_len)
                        report_mismatch("decoded_length", m_axis_tdata[47:16], want.dec_len);
                    if (m_axis_tuser[0] !== want.rec_valid)
                        report_mismatch("recovered_valid", m_axis_tuser[0], want.rec_valid);
                    if (m_axis_tuser[1] !== want.need_byte)
                        report_mismatch("need_message_byte", m_axis_tuser[1], want.need_byte);
                    if (m_axis_tuser[2] !== want.finished)
                        report_mismatch("finished", m_axis_tuser[2], want.finished);
                end
            end
        end
    end

    initial begin : rx_pacing
        int unsigned style;
        int unsigned span;
        logic        long_hold_done;
        long_hold_done = 1'b0;
        forever begin
            if (!long_hold_done && outputs_seen >= 300) begin
                // long back-pressure so the output register fills and input stalls
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_done = 1'b1;
            end
            style = $urandom_range(0, 3);
            span  = $urandom_range(8, 64);
            repeat (span) begin
                case (style)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= logic'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        int r;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (r = 0; r < $size(script); r++) begin
            case (script[r].kind)
                ROW_ITEM: begin
                    send_item(script[r].sof, script[r].carrier, script[r].msg,
                              script[r].typed, script[r].want);
                end
                ROW_SET_MODE: begin
                    stream_idle();
                    reg_write(lse_pkg::REG_EXTRACT_MODE, script[r].value);
                end
                default: begin
                    stream_idle();
                    reg_write(lse_pkg::REG_EMBED_LENGTH, script[r].value);
                end
            endcase
        end
        while (items_sent < N_ITEMS)
            send_image();
        stream_idle();
        repeat (8) @(posedge i_clk);
        if (pending_outputs.size() != 0)
            report_mismatch("missing transfers", pending_outputs.size(), 0);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/lse_pkg.sv
hw/rtl/lsb_stego_embed_extract_unit.sv
tb/tb_lsb_stego_embed_extract_unit.sv
